/* hdl/cda_pkg.sv */
// ---------------------------------------------------------------------------
// cda_pkg: shared definitions for the date-plus-days block
// Widths, status codes, sequencer states and the Gregorian month tables.
// ---------------------------------------------------------------------------
`default_nettype none

package cda_pkg;

  localparam int OFFSET_WIDTH_DEF = 16;
  localparam int DAY_W            = 5;
  localparam int MONTH_W          = 4;
  localparam int YEAR_W           = 14;
  localparam int DOY_W            = 9;
  localparam int STATUS_W         = 2;

  localparam logic [YEAR_W-1:0]  MAX_YEAR   = YEAR_W'(9999);
  localparam logic [YEAR_W-1:0]  QUAD_CENT  = YEAR_W'(400);
  localparam logic [MONTH_W-1:0] LAST_MONTH = MONTH_W'(12);

  localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_BAD_MONTH = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_BAD_DAY   = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_OVERFLOW  = 2'd3;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MOD   = 6'b000010,
    S_CHECK = 6'b000100,
    S_CARRY = 6'b001000,
    S_MONTH = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  // Leap test from year mod 400: divisible by 4, but not a plain century.
  function automatic logic is_leap(input logic [8:0] rem);
    return (rem[1:0] == 2'd0) && (rem != 9'd100) && (rem != 9'd200) && (rem != 9'd300);
  endfunction

  // 1-based day of year on which month (idx + 1) starts; idx 12 is year length + 1.
  function automatic logic [DOY_W-1:0] month_start(input logic leap,
                                                   input logic [MONTH_W-1:0] idx);
    logic [DOY_W-1:0] base;
    base = '0;
    unique case (idx)
      4'd0:    base = 9'd1;
      4'd1:    base = 9'd32;
      4'd2:    base = 9'd60;
      4'd3:    base = 9'd91;
      4'd4:    base = 9'd121;
      4'd5:    base = 9'd152;
      4'd6:    base = 9'd182;
      4'd7:    base = 9'd213;
      4'd8:    base = 9'd244;
      4'd9:    base = 9'd274;
      4'd10:   base = 9'd305;
      4'd11:   base = 9'd335;
      4'd12:   base = 9'd366;
      default: base = 9'd0;
    endcase
    if (leap && (idx >= 4'd2) && (idx <= 4'd12)) begin
      base = base + 9'd1;
    end
    return base;
  endfunction

  // Length of month 1..12; 0 for codes that are not months.
  function automatic logic [DAY_W-1:0] month_len(input logic leap,
                                                 input logic [MONTH_W-1:0] month);
    logic [DAY_W-1:0] len;
    len = '0;
    unique case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

/* hdl/cda_sub_unit.sv */
// ---------------------------------------------------------------------------
// cda_sub_unit: shared subtract / compare unit
// One W-bit subtractor with borrow out; borrow set means a < b.
// ---------------------------------------------------------------------------
`default_nettype none

module cda_sub_unit #(
  parameter int W = 14
) (
  input  wire logic [W-1:0] a,
  input  wire logic [W-1:0] b,
  output logic      [W-1:0] diff,
  output logic              borrow
);

  logic [W:0] full;

  assign full   = {1'b0, a} - {1'b0, b};
  assign diff   = full[W-1:0];
  assign borrow = full[W];

endmodule

`default_nettype wire

/* hdl/calendar_date_add_days.sv */
// ---------------------------------------------------------------------------
// calendar_date_add_days: Gregorian date plus a day offset
// Validates the start date, adds the offset, carries whole years and splits
// the count back into month and day; the mod-400 pass, the year carry and the month search share one subtractor.
// ---------------------------------------------------------------------------
// Sequence: S_MOD reduces the start year mod 400 by repeated subtraction,
//   S_CHECK validates the date, S_CARRY carries one whole year per step (about
//   offset / 365 years in all), S_MONTH walks the month starts and S_DONE
//   registers the result; a start year near 9819 with a full 16-bit offset
//   carries 180 years, the most.
// Flow: one transaction at a time, the next taken once the sequencer is idle;
//   a finished result waits in the output register while the next is taken.
// Reset: rst_n (sync, active low) idles the sequencer and drops out_valid.
// ---------------------------------------------------------------------------
`default_nettype none

module calendar_date_add_days #(
  parameter int OFFSET_WIDTH = cda_pkg::OFFSET_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input channel
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [cda_pkg::DAY_W-1:0]     in_day,
  input  wire logic [cda_pkg::MONTH_W-1:0]   in_month,
  input  wire logic [cda_pkg::YEAR_W-1:0]    in_year,
  input  wire logic [OFFSET_WIDTH-1:0]       in_offset_days,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [cda_pkg::DAY_W-1:0]     out_day,
  output logic      [cda_pkg::MONTH_W-1:0]   out_month,
  output logic      [cda_pkg::YEAR_W-1:0]    out_year,
  output logic      [cda_pkg::DOY_W-1:0]     out_day_of_year,
  output logic                               out_leap_year,
  output logic      [cda_pkg::STATUS_W-1:0]  out_status
);

  // Day count after adding the offset: at most 366 + 2^OFFSET_WIDTH - 1.
  localparam int DAYS_W = ((OFFSET_WIDTH > 9) ? OFFSET_WIDTH : 9) + 1;
  // Shared unit must also hold a raw 14-bit year for the mod-400 pass.
  localparam int UNIT_W = (DAYS_W > cda_pkg::YEAR_W) ? DAYS_W : cda_pkg::YEAR_W;

  cda_pkg::state_t state_r, state_nxt;

  // working registers
  logic [cda_pkg::DAY_W-1:0]    day_r,    day_nxt;
  logic [cda_pkg::MONTH_W-1:0]  month_r,  month_nxt;   // start month, then search index
  logic [cda_pkg::YEAR_W-1:0]   year_r,   year_nxt;
  logic [cda_pkg::YEAR_W-1:0]   rem_r,    rem_nxt;     // year mod 400 once S_MOD ends
  logic [OFFSET_WIDTH-1:0]      offset_r, offset_nxt;
  logic [DAYS_W-1:0]            days_r,   days_nxt;
  logic [cda_pkg::STATUS_W-1:0] stat_r,   stat_nxt;

  // output register
  logic                         out_valid_r, out_valid_nxt;
  logic [cda_pkg::DAY_W-1:0]    out_day_r,   out_day_nxt;
  logic [cda_pkg::MONTH_W-1:0]  out_month_r, out_month_nxt;
  logic [cda_pkg::YEAR_W-1:0]   out_year_r,  out_year_nxt;
  logic [cda_pkg::DOY_W-1:0]    out_doy_r,   out_doy_nxt;
  logic                         out_leap_r,  out_leap_nxt;
  logic [cda_pkg::STATUS_W-1:0] out_stat_r,  out_stat_nxt;

  // shared subtractor
  logic [UNIT_W-1:0] op_a, op_b, sub_diff;
  logic              sub_borrow;

  cda_sub_unit #(
    .W (UNIT_W)
  ) u_sub (
    .a      (op_a),
    .b      (op_b),
    .diff   (sub_diff),
    .borrow (sub_borrow)
  );

  // leap flag of the year in year_r; valid from S_CHECK onward
  logic                       leap;
  logic [cda_pkg::DOY_W-1:0]  year_len;
  logic [cda_pkg::DOY_W-1:0]  search_start;
  logic [cda_pkg::DOY_W-1:0]  start_doy;
  logic [cda_pkg::DOY_W-1:0]  day_in_month;
  logic                       out_free;
  logic                       accept;

  assign leap         = cda_pkg::is_leap(rem_r[8:0]);
  assign year_len     = leap ? 9'd366 : 9'd365;
  assign search_start = cda_pkg::month_start(leap, month_r);
  assign start_doy    = cda_pkg::month_start(leap, month_r - 4'd1);
  assign day_in_month = days_r[cda_pkg::DOY_W-1:0] - start_doy + 9'd1;
  assign out_free     = !out_valid_r || !out_stall;
  assign accept       = in_valid && !in_stall;

  // operand select for the shared unit
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (state_r)
      cda_pkg::S_MOD: begin
        op_a = UNIT_W'(rem_r);
        op_b = UNIT_W'(cda_pkg::QUAD_CENT);
      end
      cda_pkg::S_CARRY: begin
        op_a = UNIT_W'(days_r);
        op_b = UNIT_W'(year_len);
      end
      cda_pkg::S_MONTH: begin
        op_a = UNIT_W'(days_r);
        op_b = UNIT_W'(search_start);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    day_nxt       = day_r;
    month_nxt     = month_r;
    year_nxt      = year_r;
    rem_nxt       = rem_r;
    offset_nxt    = offset_r;
    days_nxt      = days_r;
    stat_nxt      = stat_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_day_nxt   = out_day_r;
    out_month_nxt = out_month_r;
    out_year_nxt  = out_year_r;
    out_doy_nxt   = out_doy_r;
    out_leap_nxt  = out_leap_r;
    out_stat_nxt  = out_stat_r;

    unique case (state_r)
      cda_pkg::S_IDLE: begin
        if (accept) begin
          day_nxt    = in_day;
          month_nxt  = in_month;
          year_nxt   = in_year;
          rem_nxt    = in_year;
          offset_nxt = in_offset_days;
          stat_nxt   = cda_pkg::STAT_OK;
          state_nxt  = cda_pkg::S_MOD;
        end
      end

      // year mod 400 by repeated subtraction
      cda_pkg::S_MOD: begin
        if (!sub_borrow) begin
          rem_nxt = sub_diff[cda_pkg::YEAR_W-1:0];
        end else begin
          state_nxt = cda_pkg::S_CHECK;
        end
      end

      // month, then day, then year; load start day count
      cda_pkg::S_CHECK: begin
        state_nxt = cda_pkg::S_CARRY;
        if ((month_r == 4'd0) || (month_r > cda_pkg::LAST_MONTH)) begin
          stat_nxt  = cda_pkg::STAT_BAD_MONTH;
          state_nxt = cda_pkg::S_DONE;
        end else if ((day_r == 5'd0) || (day_r > cda_pkg::month_len(leap, month_r))) begin
          stat_nxt  = cda_pkg::STAT_BAD_DAY;
          state_nxt = cda_pkg::S_DONE;
        end else if (year_r > cda_pkg::MAX_YEAR) begin
          stat_nxt  = cda_pkg::STAT_OVERFLOW;
          state_nxt = cda_pkg::S_DONE;
        end
        days_nxt = DAYS_W'(start_doy) - DAYS_W'(1) + DAYS_W'(day_r) + DAYS_W'(offset_r);
      end

      // carry whole years while the count exceeds this year's length
      cda_pkg::S_CARRY: begin
        if (!sub_borrow && (sub_diff != '0) && (year_r <= cda_pkg::MAX_YEAR)) begin
          days_nxt = sub_diff[DAYS_W-1:0];
          year_nxt = year_r + 14'd1;
          rem_nxt  = (rem_r[8:0] == 9'd399) ? '0 : rem_r + 14'd1;
        end else if (year_r > cda_pkg::MAX_YEAR) begin
          stat_nxt  = cda_pkg::STAT_OVERFLOW;
          state_nxt = cda_pkg::S_DONE;
        end else begin
          month_nxt = 4'd1;
          state_nxt = cda_pkg::S_MONTH;
        end
      end

      // walk month starts until the count falls below the next one
      cda_pkg::S_MONTH: begin
        if ((month_r < cda_pkg::LAST_MONTH) && !sub_borrow) begin
          month_nxt = month_r + 4'd1;
        end else begin
          state_nxt = cda_pkg::S_DONE;
        end
      end

      cda_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_stat_nxt  = stat_r;
          if (stat_r == cda_pkg::STAT_OK) begin
            out_day_nxt   = day_in_month[cda_pkg::DAY_W-1:0];
            out_month_nxt = month_r;
            out_year_nxt  = year_r;
            out_doy_nxt   = days_r[cda_pkg::DOY_W-1:0];
            out_leap_nxt  = leap;
          end else begin
            out_day_nxt   = '0;
            out_month_nxt = '0;
            out_year_nxt  = '0;
            out_doy_nxt   = '0;
            out_leap_nxt  = 1'b0;
          end
          state_nxt = cda_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = cda_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cda_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    day_r       <= day_nxt;
    month_r     <= month_nxt;
    year_r      <= year_nxt;
    rem_r       <= rem_nxt;
    offset_r    <= offset_nxt;
    days_r      <= days_nxt;
    stat_r      <= stat_nxt;
    out_day_r   <= out_day_nxt;
    out_month_r <= out_month_nxt;
    out_year_r  <= out_year_nxt;
    out_doy_r   <= out_doy_nxt;
    out_leap_r  <= out_leap_nxt;
    out_stat_r  <= out_stat_nxt;
  end

  // a new transaction is taken only while the sequencer is idle
  assign in_stall        = (state_r != cda_pkg::S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_day         = out_day_r;
  assign out_month       = out_month_r;
  assign out_year        = out_year_r;
  assign out_day_of_year = out_doy_r;
  assign out_leap_year   = out_leap_r;
  assign out_status      = out_stat_r;

endmodule

`default_nettype wire
